/* src/drc_pkg.sv */
`default_nettype none
package drc_pkg;

    localparam int TARGET_BITS_DEF = 256;
    // A target with a set bit among its top WIDE_MARGIN positions is halved
    // before scaling.
    localparam int WIDE_MARGIN     = 21;
    localparam int MANT_W          = 23;
    localparam int SPAN_W          = 33;
    localparam int PROD_W          = MANT_W + SPAN_W;
    localparam int SHIFT_W         = 11;
    localparam int TS_W            = 31;
    localparam int LS_W            = 8;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SPAN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_RETARGET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_SHIFT = 2'd2;

    localparam logic [TS_W-1:0] TS_RESET = 31'd1209600;
    localparam logic [LS_W-1:0] LS_RESET = 8'd20;

    typedef struct packed {
        logic [31:0] prev;
        logic        wide;
    } t_side;

endpackage
`default_nettype wire

/* src/drc_front.sv */
`default_nettype none
module drc_front
    import drc_pkg::*;
#(
    parameter int TB = TARGET_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire logic [31:0]     i_prev_bits,
    input  wire logic [31:0]     i_last_time,
    input  wire logic [31:0]     i_first_time,
    input  wire logic [TS_W-1:0] i_target_span,
    output logic [TB-1:0]        o_p,
    output t_side                o_side
);

    logic [7:0]         size;
    logic [MANT_W-1:0]  mant;
    logic               short_exp;
    logic [4:0]         rsh;
    logic [SHIFT_W-1:0] off;
    logic [SHIFT_W-1:0] keep;
    logic [MANT_W-1:0]  w0;
    logic [TB-1:0]      v;
    logic               wide;
    logic [MANT_W-1:0]  w;
    logic [SHIFT_W-1:0] t;
    logic signed [33:0] span_raw;
    logic signed [33:0] lo;
    logic signed [33:0] hi;
    logic signed [33:0] span_c;

    logic [MANT_W-1:0]  r_w;
    logic [SHIFT_W-1:0] r_t;
    logic [SPAN_W-1:0]  r_span;
    t_side              r_side_a;
    logic [PROD_W-1:0]  r_prod;
    logic [SHIFT_W-1:0] r_t2;
    t_side              r_side_b;
    logic [TB-1:0]      r_p;
    t_side              r_side_c;

    always_comb begin
        size      = i_prev_bits[31:24];
        mant      = i_prev_bits[MANT_W-1:0];
        short_exp = (size <= 8'd3);
        rsh       = {(2'd3 - size[1:0]), 3'b000};
        off       = {(size - 8'd3), 3'b000};
        keep      = SHIFT_W'(TB) - off;
        if (off >= SHIFT_W'(TB)) begin
            w0 = '0;
        end else if (keep >= SHIFT_W'(MANT_W)) begin
            w0 = mant;
        end else begin
            w0 = mant & ~({MANT_W{1'b1}} << keep[4:0]);
        end
        v    = {{(TB-MANT_W){1'b0}}, w0} << off;
        wide = !short_exp && (|v[TB-1:TB-WIDE_MARGIN]);
        if (short_exp) begin
            w = mant >> rsh;
            t = '0;
        end else begin
            w = w0;
            t = wide ? (off - SHIFT_W'(1)) : off;
        end

        span_raw = signed'({2'b00, i_last_time}) - signed'({2'b00, i_first_time});
        lo       = signed'({3'b000, (i_target_span >> 2)});
        hi       = signed'({1'b0, i_target_span, 2'b00});
        span_c   = span_raw;
        if (span_c < lo) begin
            span_c = lo;
        end
        if (span_c > hi) begin
            span_c = hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w           <= w;
            r_t           <= t;
            r_span        <= span_c[SPAN_W-1:0];
            r_side_a.prev <= i_prev_bits;
            r_side_a.wide <= wide;
            r_prod        <= PROD_W'(r_w) * PROD_W'(r_span);
            r_t2          <= r_t;
            r_side_b      <= r_side_a;
            r_p           <= {{(TB-PROD_W){1'b0}}, r_prod} << r_t2;
            r_side_c      <= r_side_b;
        end
    end

    assign o_p    = r_p;
    assign o_side = r_side_c;

endmodule
`default_nettype wire

/* src/drc_cell.sv */
`default_nettype none
module drc_cell
    import drc_pkg::*;
#(
    parameter int TB = TARGET_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire logic [TS_W-1:0] i_div,
    input  wire logic [TB-1:0]   i_word,
    input  wire logic [TS_W-1:0] i_rem,
    input  wire t_side           i_side,
    output logic [TB-1:0]        o_word,
    output logic [TS_W-1:0]      o_rem,
    output t_side                o_side
);

    // One restoring division step: the dividend shifts out at the top while
    // quotient bits shift in at the bottom of the same word.
    logic [TS_W:0] cur;
    logic [TS_W:0] diff;
    logic          ge;

    logic [TB-1:0]   r_word;
    logic [TS_W-1:0] r_rem;
    t_side           r_side;

    always_comb begin
        cur  = {i_rem, i_word[TB-1]};
        ge   = (cur >= {1'b0, i_div});
        diff = cur - {1'b0, i_div};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= {i_word[TB-2:0], ge};
            r_rem  <= ge ? diff[TS_W-1:0] : cur[TS_W-1:0];
            r_side <= i_side;
        end
    end

    assign o_word = r_word;
    assign o_rem  = r_rem;
    assign o_side = r_side;

endmodule
`default_nettype wire

/* src/drc_back.sv */
`default_nettype none
module drc_back
    import drc_pkg::*;
#(
    parameter int TB = TARGET_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire logic [TB-1:0]   i_q,
    input  wire t_side           i_side,
    input  wire logic            i_no_retarget,
    input  wire logic [LS_W-1:0] i_limit_shift,
    output logic [31:0]          o_next_bits
);

    localparam int BL_W = $clog2(TB + 1);

    logic [TB-1:0]      q2;
    logic [TB-1:0]      lim;
    logic [TB-1:0]      r_val;
    t_side              r_side;
    logic [BL_W-1:0]    blen;
    logic [7:0]         size;
    logic [SHIFT_W-1:0] off;
    logic [23:0]        c;
    logic [31:0]        enc;
    logic [31:0]        r_out;

    always_comb begin
        q2  = i_side.wide ? {i_q[TB-2:0], 1'b0} : i_q;
        lim = {TB{1'b1}} >> i_limit_shift;
    end

    always_comb begin
        blen = '0;
        for (int i = 0; i < TB; i++) begin
            if (r_val[i]) begin
                blen = BL_W'(i + 1);
            end
        end
        size = 8'((blen + BL_W'(7)) >> 3);
        off  = {(size - 8'd3), 3'b000};
        if (size <= 8'd3) begin
            c = r_val[23:0] << {(2'd3 - size[1:0]), 3'b000};
        end else begin
            c = 24'(r_val >> off);
        end
        if (c[23]) begin
            c    = c >> 8;
            size = size + 8'd1;
        end
        enc = {size, 1'b0, c[MANT_W-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val  <= (q2 > lim) ? lim : q2;
            r_side <= i_side;
            r_out  <= i_no_retarget ? r_side.prev : enc;
        end
    end

    assign o_next_bits = r_out;

endmodule
`default_nettype wire

/* src/difficulty_retarget_compact.sv */
// Throughput: one word per cycle while the output is not stalled; the long
// division is a row of TB cells, one quotient bit each, and the whole
// pipeline advances together.
// When a result waits on a stalled output the pipeline holds and input stalls.
// Reset (synchronous, active low) empties the pipeline and restores the
// configuration registers to their defaults.
`default_nettype none
module difficulty_retarget_compact
    import drc_pkg::*;
#(
    parameter int TB = TARGET_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [31:0]          i_prev_bits,
    input  wire logic [31:0]          i_last_time,
    input  wire logic [31:0]          i_first_time,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [31:0]               o_next_bits,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [TS_W-1:0]      i_cfg_data
);

    localparam int NST = TB + 5;

    logic            adv;
    logic [NST-1:0]  r_vld;
    logic [TS_W-1:0] r_ts;
    logic            r_nr;
    logic [LS_W-1:0] r_ls;

    logic [TB-1:0]   word  [TB+1];
    logic [TS_W-1:0] rem   [TB+1];
    t_side           side  [TB+1];

    assign adv     = !(r_vld[NST-1] && i_stall);
    assign o_stall = !adv;
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ts  <= TS_RESET;
            r_nr  <= 1'b0;
            r_ls  <= LS_RESET;
        end else begin
            if (adv) begin
                r_vld <= {r_vld[NST-2:0], i_valid};
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TARGET_SPAN: r_ts <= i_cfg_data;
                    CFG_NO_RETARGET: r_nr <= i_cfg_data[0];
                    CFG_LIMIT_SHIFT: r_ls <= i_cfg_data[LS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    drc_front #(.TB(TB)) u_front (
        .i_clk         (i_clk),
        .i_en          (adv),
        .i_prev_bits   (i_prev_bits),
        .i_last_time   (i_last_time),
        .i_first_time  (i_first_time),
        .i_target_span (r_ts),
        .o_p           (word[0]),
        .o_side        (side[0])
    );

    assign rem[0] = '0;

    for (genvar k = 0; k < TB; k++) begin : g_cell
        drc_cell #(.TB(TB)) u_cell (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_div  (r_ts),
            .i_word (word[k]),
            .i_rem  (rem[k]),
            .i_side (side[k]),
            .o_word (word[k+1]),
            .o_rem  (rem[k+1]),
            .o_side (side[k+1])
        );
    end

    drc_back #(.TB(TB)) u_back (
        .i_clk         (i_clk),
        .i_en          (adv),
        .i_q           (word[TB]),
        .i_side        (side[TB]),
        .i_no_retarget (r_nr),
        .i_limit_shift (r_ls),
        .o_next_bits   (o_next_bits)
    );

endmodule
`default_nettype wire

/* tb/tb_checker.sv */
`timescale 1ns / 1ps
module tb_checker
    import drc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic                 i_o_stall,
    input  wire logic [31:0]          i_prev_bits,
    input  wire logic [31:0]          i_last_time,
    input  wire logic [31:0]          i_first_time,
    input  wire logic                 i_o_valid,
    input  wire logic                 i_stall,
    input  wire logic [31:0]          i_next_bits,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [TS_W-1:0]      i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);

    logic [TS_W-1:0] span_goal;
    logic            pass_thru;
    logic [LS_W-1:0] lim_shift;
    logic [31:0]     next_bits_q[$];

    function automatic int bit_length(logic [255:0] v);
        for (int i = 255; i >= 0; i--) begin
            if (v[i]) return i + 1;
        end
        return 0;
    endfunction

    function automatic logic [31:0] retarget(logic [31:0] prev, logic [31:0] last_t,
                                             logic [31:0] first_t);
        longint      span;
        longint      lo;
        longint      hi;
        logic [7:0]  size;
        logic [22:0] mant;
        logic [255:0] tgt;
        logic [255:0] limit;
        logic [255:0] sh;
        logic        wide;
        logic [31:0] c;
        int          blen;
        if (pass_thru) return prev;
        span = longint'(last_t) - longint'(first_t);
        lo = longint'(span_goal / 4);
        hi = longint'(span_goal) * 4;
        if (span < lo) span = lo;
        if (span > hi) span = hi;
        // Decode the compact word; the sign bit is ignored.
        size = prev[31:24];
        mant = prev[22:0];
        if (size <= 3) tgt = 256'(mant) >> (8 * (3 - size));
        else tgt = 256'(mant) << (8 * (int'(size) - 3));
        wide = bit_length(tgt) > 235;
        if (wide) tgt = tgt >> 1;
        tgt = tgt * 256'(span);
        if (span_goal == 0) tgt = '1;
        else tgt = tgt / 256'(span_goal);
        if (wide) tgt = tgt << 1;
        limit = {256{1'b1}} >> lim_shift;
        if (tgt > limit) tgt = limit;
        // Re-encode to compact form.
        blen = bit_length(tgt);
        size = 8'((blen + 7) / 8);
        if (size <= 3) begin
            c = {8'd0, tgt[23:0]} << (8 * (3 - size));
        end else begin
            sh = tgt >> (8 * (int'(size) - 3));
            c = {8'd0, sh[23:0]};
        end
        if (c[23]) begin
            c = c >> 8;
            size = size + 1;
        end
        return {size, 1'b0, c[22:0]};
    endfunction

    assign o_pending = next_bits_q.size();

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            span_goal <= TS_RESET;
            pass_thru <= 1'b0;
            lim_shift <= LS_RESET;
            next_bits_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TARGET_SPAN: span_goal <= i_cfg_data;
                    CFG_NO_RETARGET: pass_thru <= i_cfg_data[0];
                    CFG_LIMIT_SHIFT: lim_shift <= i_cfg_data[LS_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && !i_o_stall)
                next_bits_q.push_back(retarget(i_prev_bits, i_last_time, i_first_time));
            if (i_o_valid && !i_stall) begin
                if (next_bits_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("ERROR: unexpected word next_bits=%h", i_next_bits);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = next_bits_q.pop_front();
                    if (want !== i_next_bits) begin
                        if (o_fail_count < 10)
                            $display("ERROR: next_bits expected %h actual %h",
                                     want, i_next_bits);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import drc_pkg::*;

    localparam int LATENCY   = 260;
    localparam int WATCHDOG  = 6000;
    localparam int HOLD_LEN  = 700;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [31:0]          i_prev_bits = '0;
    logic [31:0]          i_last_time = '0;
    logic [31:0]          i_first_time = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [31:0]          o_next_bits;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_TARGET_SPAN;
    logic [TS_W-1:0]      i_cfg_data = '0;

    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    logic        hold_go = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_cnt = 0;
    int          quiet_cycles = 0;
    logic [30:0] span_now = TS_RESET;

    difficulty_retarget_compact dut (.*);

    tb_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_o_stall(o_stall),
        .i_prev_bits(i_prev_bits), .i_last_time(i_last_time),
        .i_first_time(i_first_time), .i_o_valid(o_valid), .i_stall(i_stall),
        .i_next_bits(o_next_bits), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Receiver: random stalls, plus one long hold-off so the pipeline fills.
    always @(posedge i_clk) begin
        if (hold_go != hold_seen) begin
            hold_seen <= hold_go;
            hold_cnt <= HOLD_LEN;
            i_stall <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_word(logic [31:0] prev, logic [31:0] last_t, logic [31:0] first_t);
        logic stalled;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_prev_bits <= prev;
        i_last_time <= last_t;
        i_first_time <= first_t;
        forever begin
            @(negedge i_clk);
            stalled = o_stall;
            @(posedge i_clk);
            if (!stalled) break;
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // The write enable stays high across back-to-back writes; set_config drops it.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TS_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == CFG_TARGET_SPAN) span_now = data;
    endtask

    task automatic set_config(logic [TS_W-1:0] ts, logic nr, logic [LS_W-1:0] ls);
        drain();
        write_reg(CFG_TARGET_SPAN, ts);
        write_reg(CFG_NO_RETARGET, TS_W'(nr));
        write_reg(CFG_LIMIT_SHIFT, TS_W'(ls));
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_words(int n);
        logic [31:0] prev;
        logic [31:0] first_t;
        logic [31:0] last_t;
        longint      delta;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) < 7)
                prev = {8'($urandom_range(34)), 24'($urandom)};
            else
                prev = $urandom;
            first_t = $urandom;
            // Mostly spans around the goal, so both clamps and the middle are hit.
            if ($urandom_range(3) != 0) begin
                delta = longint'($urandom) % (longint'(span_now) * 5 + 1);
                last_t = first_t + 32'(delta);
            end else begin
                last_t = $urandom;
            end
            send_word(prev, last_t, first_t);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words at reset settings.
        send_word(32'h0000_0000, 32'd1209600, 32'd0);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(32'h1D00_FFFF, 32'd1209600, 32'd0);
        send_word(32'h0100_3456, 32'd100, 32'd0);
        send_word(32'h0200_8000, 32'd5000000, 32'd0);
        send_word(32'h0312_3456, 32'd0, 32'hFFFF_FFFF);
        send_word(32'h0492_3456, 32'd2000000, 32'd1000000);
        send_word(32'h1F7F_FFFF, 32'd2419200, 32'd0);
        send_word(32'h20FF_FFFF, 32'd300000, 32'd0);
        send_word(32'h2100_8000, 32'd600000, 32'd0);
        send_word(32'hFF7F_FFFF, 32'd1209600, 32'd0);
        send_word(32'h1B7F_FFFF, 32'd4838400, 32'd0);
        send_word(32'h1C00_0001, 32'd1, 32'd1);
        send_word(32'h0380_0000, 32'd10, 32'd20);
        send_word(32'h1A44_3322, 32'hFFFF_FFFF, 32'hFFFF_FFFE);

        set_config(31'd4, 1'b0, 8'd0);
        send_word(32'h2000_FFFF, 32'd16, 32'd0);
        send_word(32'h207F_FFFF, 32'd1, 32'd0);
        send_word(32'h0412_3456, 32'd7, 32'd2);
        set_config(31'd0, 1'b0, 8'd255);
        send_word(32'h1D00_FFFF, 32'd5, 32'd0);
        send_word(32'h0000_0000, 32'd5, 32'd0);
        set_config(31'd3, 1'b1, 8'd8);
        send_word(32'hFFFF_FFFF, 32'd5, 32'd0);
        send_word(32'h1D80_FFFF, 32'd5, 32'd9);

        // Random part, one idling mix per phase, several register settings.
        set_config(TS_RESET, 1'b0, LS_RESET);
        send_idle_pct = 0; stall_pct = 0;
        random_words(300);
        send_idle_pct = 87; stall_pct = 0;
        random_words(200);
        set_config(31'h7FFF_FFFF, 1'b0, 8'd0);
        send_idle_pct = 0; stall_pct = 87;
        random_words(200);
        set_config(31'd600, 1'b0, 8'd1);
        send_idle_pct = 22; stall_pct = 22;
        random_words(250);
        set_config(31'd1, 1'b0, 8'd100);
        send_idle_pct = 0; stall_pct = 0;
        hold_go <= ~hold_go;
        random_words(200);
        set_config(31'd150, 1'b1, 8'd32);
        send_idle_pct = 22; stall_pct = 22;
        random_words(100);
        set_config(31'd86400, 1'b0, 8'd255);
        send_idle_pct = 0; stall_pct = 87;
        random_words(100);
        set_config(31'd2, 1'b0, 8'd20);
        send_idle_pct = 87; stall_pct = 22;
        random_words(150);

        drain();
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
